### rtl/core/qpos_pkg.sv
// ----------------------------------------------------------------------------
// qpos_pkg: shared types and constants
// Opcodes, sequencer states and prefix entry layout for the QBF search block.
// ----------------------------------------------------------------------------
package qpos_pkg;

   localparam int VAR_BITS = 32;   // variable masks cover every 5-bit index
   localparam int TDATA_IN_W = 16;
   localparam int TDATA_OUT_W = 8;

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_ADDLIT = 3'd1,
      OP_CLOSE  = 3'd2,
      OP_PREFIX = 3'd3,
      OP_FIX    = 3'd4,
      OP_SOLVE  = 3'd5,
      OP_RSVD6  = 3'd6,   // reserved, ignored
      OP_RSVD7  = 3'd7    // reserved, ignored
   } opcode_type;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_EV_RD  = 8'b0000_0010,
      ST_EV_CHK = 8'b0000_0100,
      ST_NX_RD  = 8'b0000_1000,
      ST_NX_CHK = 8'b0001_0000,
      ST_BT_RD  = 8'b0010_0000,
      ST_BT_CHK = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic       univ;
      logic [4:0] var_idx;
   } entry_type;

   // search stack word: entry plus branch flag (1 = false branch running)
   typedef struct packed {
      logic      second;
      entry_type entry;
   } frame_type;

endpackage

### rtl/core/qpos_clause_mem.sv
// ----------------------------------------------------------------------------
// qpos_clause_mem: clause literal table
// One write port, one registered read port; positive and negative masks.
// ----------------------------------------------------------------------------
module qpos_clause_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [qpos_pkg::VAR_BITS-1:0] wr_pos,
   input  logic [qpos_pkg::VAR_BITS-1:0] wr_neg,
   input  logic [AW-1:0]                 rd_addr,
   output logic [qpos_pkg::VAR_BITS-1:0] rd_pos,
   output logic [qpos_pkg::VAR_BITS-1:0] rd_neg
);

   logic [qpos_pkg::VAR_BITS-1:0] pos_mem [DEPTH];
   logic [qpos_pkg::VAR_BITS-1:0] neg_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pos_mem[wr_addr] <= wr_pos;
         neg_mem[wr_addr] <= wr_neg;
      end
      rd_pos <= pos_mem[rd_addr];
      rd_neg <= neg_mem[rd_addr];
   end

endmodule

### rtl/core/qbf_prefix_order_search_top.sv
// ----------------------------------------------------------------------------
// qbf_prefix_order_search_top: prenex CNF QBF decider
// Depth-first search over the quantifier prefix with a shared clause checker.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command transaction: clear, add literal, close clause,
//   append prefix variable, fix variable or solve. Load commands produce no
//   response. Solve produces one rsp_* transaction holding the satisfiable
//   bit and the table overflow flag.
// Throughput:
//   Load commands: one per cycle while idle and no response waits. Solve:
//   the sequencer checks each clause as a table read then a check, scans
//   the prefix one entry at a time with a read then a check, and pops the
//   search stack one level at a time with a read then a check. The search
//   time is data dependent and exponential in the prefix length in the
//   worst case. The single clause-table read port sets the pace.
// Reset: synchronous, clears counts, fixed mask, overflow flag and the
//   sequencer. Table contents are only read after being written.
// Stall: req_tready stays low during a search and while a response waits
//   for rsp_tready; the response is held stable until taken.
// ----------------------------------------------------------------------------
module qbf_prefix_order_search_top #(
   parameter int MAX_VARS    = 32,
   parameter int MAX_CLAUSES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [2:0] opcode, [7:3] var_index, [8] negated, [9] universal, rest zero
   input  logic [qpos_pkg::TDATA_IN_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] satisfiable, [1] overflow, rest zero
   output logic [qpos_pkg::TDATA_OUT_W-1:0]  rsp_tdata
);

   localparam int CW  = $clog2(MAX_CLAUSES + 1);             // clause count
   localparam int CAW = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
   localparam int PLW = $clog2(MAX_VARS + 1);                // prefix length / level
   localparam int PAW = $clog2(MAX_VARS);
   localparam int VB  = qpos_pkg::VAR_BITS;

   // request fields
   logic [2:0] req_opcode;
   logic [4:0] req_var;
   logic       req_neg;
   logic       req_univ;
   assign req_opcode = req_tdata[2:0];
   assign req_var    = req_tdata[7:3];
   assign req_neg    = req_tdata[8];
   assign req_univ   = req_tdata[9];

   qpos_pkg::state_type state_ff, state_in;

   logic [CW-1:0]  clause_count_ff, clause_count_in;
   logic [PLW-1:0] prefix_len_ff, prefix_len_in;
   logic [VB-1:0]  fixed_ff, fixed_in;
   logic [VB-1:0]  open_pos_ff, open_pos_in;   // clause still open
   logic [VB-1:0]  open_neg_ff, open_neg_in;
   logic           overflow_ff, overflow_in;
   logic [VB-1:0]  dmask_ff, dmask_in;
   logic [VB-1:0]  dval_ff, dval_in;
   logic [PLW-1:0] level_ff, level_in;
   logic [CW-1:0]  cidx_ff, cidx_in;
   logic [PLW-1:0] pidx_ff, pidx_in;
   logic           all_true_ff, all_true_in;
   logic           res_ff, res_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_sat_ff, rsp_sat_in;
   logic           rsp_ovf_ff, rsp_ovf_in;

   logic accept, var_ok;
   assign req_tready = (state_ff == qpos_pkg::ST_IDLE) && !rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign var_ok     = (32'(req_var) < MAX_VARS);

   // clause table
   logic          cm_wr_en;
   logic [VB-1:0] cm_pos, cm_neg;
   qpos_clause_mem #(.DEPTH(MAX_CLAUSES), .AW(CAW)) u_clauses (
      .clock   (clock),
      .wr_en   (cm_wr_en),
      .wr_addr (clause_count_ff[CAW-1:0]),
      .wr_pos  (open_pos_ff),
      .wr_neg  (open_neg_ff),
      .rd_addr (cidx_ff[CAW-1:0]),
      .rd_pos  (cm_pos),
      .rd_neg  (cm_neg)
   );

   // prefix table and search stack
   qpos_pkg::entry_type prefix_mem [MAX_VARS];
   qpos_pkg::entry_type prefix_q;
   qpos_pkg::frame_type stack_mem [MAX_VARS];
   qpos_pkg::frame_type stack_q;
   logic                pf_wr_en, st_wr_en;
   qpos_pkg::frame_type st_wr_data;
   logic [PAW-1:0]      st_wr_addr, st_rd_addr;

   always_ff @(posedge clock) begin
      if (pf_wr_en) begin
         prefix_mem[prefix_len_ff[PAW-1:0]] <= '{univ: req_univ, var_idx: req_var};
      end
      prefix_q <= prefix_mem[pidx_ff[PAW-1:0]];
      if (st_wr_en) begin
         stack_mem[st_wr_addr] <= st_wr_data;
      end
      stack_q <= stack_mem[st_rd_addr];
   end

   logic [PLW-1:0] level_m1;
   assign level_m1   = level_ff - PLW'(1);
   assign st_rd_addr = level_m1[PAW-1:0];

   // clause checker: shared over every clause of every node
   logic [VB-1:0] dv_eff, tru;
   logic          clause_dead;
   assign dv_eff      = dval_ff & dmask_ff;
   assign tru         = (cm_pos & dv_eff) | (cm_neg & dmask_ff & ~dv_eff);
   assign clause_dead = (tru == '0) && (((cm_pos | cm_neg) & ~dmask_ff) == '0);

   logic [VB-1:0] pbit, sbit, rbit;
   assign pbit = VB'(1) << prefix_q.var_idx;
   assign sbit = VB'(1) << stack_q.entry.var_idx;
   assign rbit = VB'(1) << req_var;

   always_comb begin
      state_in        = state_ff;
      clause_count_in = clause_count_ff;
      prefix_len_in   = prefix_len_ff;
      fixed_in        = fixed_ff;
      open_pos_in     = open_pos_ff;
      open_neg_in     = open_neg_ff;
      overflow_in     = overflow_ff;
      dmask_in        = dmask_ff;
      dval_in         = dval_ff;
      level_in        = level_ff;
      cidx_in         = cidx_ff;
      pidx_in         = pidx_ff;
      all_true_in     = all_true_ff;
      res_in          = res_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_sat_in      = rsp_sat_ff;
      rsp_ovf_in      = rsp_ovf_ff;
      cm_wr_en        = 1'b0;
      pf_wr_en        = 1'b0;
      st_wr_en        = 1'b0;
      st_wr_addr      = level_ff[PAW-1:0];
      st_wr_data      = '{second: 1'b0, entry: prefix_q};

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         qpos_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  qpos_pkg::OP_CLEAR: begin
                     clause_count_in = '0;
                     prefix_len_in   = '0;
                     fixed_in        = '0;
                     open_pos_in     = '0;
                     open_neg_in     = '0;
                     overflow_in     = 1'b0;
                  end
                  qpos_pkg::OP_ADDLIT: begin
                     if (32'(clause_count_ff) >= MAX_CLAUSES) begin
                        overflow_in = 1'b1;
                     end else if (var_ok) begin
                        if (req_neg) open_neg_in = open_neg_ff | rbit;
                        else         open_pos_in = open_pos_ff | rbit;
                     end
                  end
                  qpos_pkg::OP_CLOSE: begin
                     if (32'(clause_count_ff) >= MAX_CLAUSES) begin
                        overflow_in = 1'b1;
                     end else begin
                        cm_wr_en        = 1'b1;
                        clause_count_in = clause_count_ff + CW'(1);
                        open_pos_in     = '0;
                        open_neg_in     = '0;
                     end
                  end
                  qpos_pkg::OP_PREFIX: begin
                     if (var_ok) begin
                        if (32'(prefix_len_ff) >= MAX_VARS) begin
                           overflow_in = 1'b1;
                        end else begin
                           pf_wr_en      = 1'b1;
                           prefix_len_in = prefix_len_ff + PLW'(1);
                        end
                     end
                  end
                  qpos_pkg::OP_FIX: begin
                     if (var_ok) fixed_in = fixed_ff | rbit;
                  end
                  qpos_pkg::OP_SOLVE: begin
                     dmask_in    = '0;
                     dval_in     = '0;
                     level_in    = '0;
                     cidx_in     = '0;
                     all_true_in = 1'b1;
                     res_in      = 1'b1;
                     if (clause_count_ff == '0) state_in = qpos_pkg::ST_DONE;
                     else                       state_in = qpos_pkg::ST_EV_RD;
                  end
                  default: ;
               endcase
            end
         end
         qpos_pkg::ST_EV_RD: begin
            state_in = qpos_pkg::ST_EV_CHK;
         end
         qpos_pkg::ST_EV_CHK: begin
            if (clause_dead) begin
               res_in   = 1'b0;
               state_in = qpos_pkg::ST_BT_RD;
            end else if (cidx_ff + CW'(1) == clause_count_ff) begin
               if (all_true_ff && (tru != '0)) begin
                  res_in   = 1'b1;
                  state_in = qpos_pkg::ST_BT_RD;
               end else if (prefix_len_ff == '0) begin
                  res_in   = 1'b1;
                  state_in = qpos_pkg::ST_BT_RD;
               end else begin
                  pidx_in  = '0;
                  state_in = qpos_pkg::ST_NX_RD;
               end
            end else begin
               if (tru == '0) all_true_in = 1'b0;
               cidx_in  = cidx_ff + CW'(1);
               state_in = qpos_pkg::ST_EV_RD;
            end
         end
         qpos_pkg::ST_NX_RD: begin
            state_in = qpos_pkg::ST_NX_CHK;
         end
         qpos_pkg::ST_NX_CHK: begin
            if ((((dmask_ff | fixed_ff) & pbit) == '0) && (32'(level_ff) < MAX_VARS)) begin
               // decide this variable, true branch first
               st_wr_en    = 1'b1;
               st_wr_data  = '{second: 1'b0, entry: prefix_q};
               dmask_in    = dmask_ff | pbit;
               dval_in     = dval_ff | pbit;
               level_in    = level_ff + PLW'(1);
               cidx_in     = '0;
               all_true_in = 1'b1;
               state_in    = qpos_pkg::ST_EV_RD;
            end else if ((((dmask_ff | fixed_ff) & pbit) == '0)
                         || (pidx_ff + PLW'(1) == prefix_len_ff)) begin
               res_in   = 1'b1;
               state_in = qpos_pkg::ST_BT_RD;
            end else begin
               pidx_in  = pidx_ff + PLW'(1);
               state_in = qpos_pkg::ST_NX_RD;
            end
         end
         qpos_pkg::ST_BT_RD: begin
            if (level_ff == '0) state_in = qpos_pkg::ST_DONE;
            else                state_in = qpos_pkg::ST_BT_CHK;
         end
         qpos_pkg::ST_BT_CHK: begin
            if (!stack_q.second && (stack_q.entry.univ ? res_ff : !res_ff)) begin
               // try the false branch
               st_wr_en    = 1'b1;
               st_wr_addr  = level_m1[PAW-1:0];
               st_wr_data  = '{second: 1'b1, entry: stack_q.entry};
               dval_in     = dval_ff & ~sbit;
               cidx_in     = '0;
               all_true_in = 1'b1;
               state_in    = qpos_pkg::ST_EV_RD;
            end else begin
               dmask_in = dmask_ff & ~sbit;
               dval_in  = dval_ff & ~sbit;
               level_in = level_m1;
               state_in = qpos_pkg::ST_BT_RD;
            end
         end
         qpos_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_sat_in   = res_ff;
            rsp_ovf_in   = overflow_ff;
            dmask_in     = '0;
            dval_in      = '0;
            level_in     = '0;
            state_in     = qpos_pkg::ST_IDLE;
         end
         default: state_in = qpos_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= qpos_pkg::ST_IDLE;
         clause_count_ff <= '0;
         prefix_len_ff   <= '0;
         fixed_ff        <= '0;
         open_pos_ff     <= '0;
         open_neg_ff     <= '0;
         overflow_ff     <= 1'b0;
         dmask_ff        <= '0;
         dval_ff         <= '0;
         level_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clause_count_ff <= clause_count_in;
         prefix_len_ff   <= prefix_len_in;
         fixed_ff        <= fixed_in;
         open_pos_ff     <= open_pos_in;
         open_neg_ff     <= open_neg_in;
         overflow_ff     <= overflow_in;
         dmask_ff        <= dmask_in;
         dval_ff         <= dval_in;
         level_ff        <= level_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cidx_ff     <= cidx_in;
      pidx_ff     <= pidx_in;
      all_true_ff <= all_true_in;
      res_ff      <= res_in;
      rsp_sat_ff  <= rsp_sat_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ovf_ff, rsp_sat_ff};

endmodule
